>>> sv/assert_macros.svh
// assertion helpers for the checker in spmp_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define SPMP_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// expression that must never hold outside reset
`define SPMP_NEVER(name, clk, rst_n, expr) \
  `SPMP_ASSERT(name, clk, rst_n, !(expr))

`endif

>>> sv/spmp_pkg.sv
`default_nettype none

package spmp_pkg;

  localparam int unsigned PAGE_SIZE = 64;
  localparam int unsigned BUF_DEPTH = 128;
  localparam int unsigned BUF_AW    = $clog2(BUF_DEPTH);
  localparam int unsigned STORE_IW  = $clog2(BUF_DEPTH + 1);
  localparam int unsigned PAGE_CW   = $clog2(PAGE_SIZE + 1);
  localparam int unsigned ADDR_W    = 16;
  localparam int unsigned BYTE_W    = 8;

  typedef enum logic [1:0] {
    MEM_NONE  = 2'd0,
    MEM_WRITE = 2'd1,
    MEM_READ  = 2'd2
  } mem_op_e;

  typedef enum logic [1:0] {
    CFG_READ  = 2'd0,
    CFG_WRITE = 2'd1,
    CFG_STORE = 2'd2,
    CFG_ACK   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    mem_op_e             mem_op;
    logic [ADDR_W-1:0]   mem_address;
    logic [BYTE_W-1:0]   mem_wdata;
    logic                tx_valid;
    logic [BYTE_W-1:0]   tx_byte;
    logic                release_bus;
    logic                last;
  } res_t;

endpackage

`default_nettype wire

>>> sv/spmp_page_buf.sv
`default_nettype none

module spmp_page_buf import spmp_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              wr_en_i,
  input  wire logic [BUF_AW-1:0] wr_addr_i,
  input  wire logic [BYTE_W-1:0] wr_data_i,
  input  wire logic [BUF_AW-1:0] rd_addr_i,
  output logic      [BYTE_W-1:0] rd_data_o
);

  logic [BYTE_W-1:0]    mem_q [BUF_DEPTH];
  logic [BUF_DEPTH-1:0] valid_q;
  logic [BYTE_W-1:0]    rd_raw_q;
  logic                 rd_valid_q;

  // storage array, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_raw_q <= mem_q[rd_addr_i];
  end

  // per-entry written flags, never-written entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      rd_valid_q <= valid_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_valid_q ? rd_raw_q : '0;

endmodule

`default_nettype wire

>>> sv/spmp_out_reg.sv
`default_nettype none

module spmp_out_reg import spmp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic load_i,
  input  wire res_t res_i,
  input  wire logic stall_i,
  output logic      ready_o,
  output logic      valid_o,
  output res_t      res_o
);

  logic valid_q;
  res_t res_q;

  // slot is free when empty or being taken this cycle
  assign ready_o = !valid_q || !stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

>>> sv/serial_page_memory_programmer_core.sv
// serial page memory programmer: one input word is either a byte from the serial host
// (req_type_i low) or a data byte returned by the external memory (req_type_i high).
// a frame is a command byte, length low/high and offset low/high; store then takes
// length+1 data bytes into a 128-entry page buffer (extra bytes are dropped) and answers
// with the ack code, write waits for one trigger byte and read starts straight after the
// offset. header, data and memory return words each give at most one result word. a read
// or write page is a burst of 64 result words, one per cycle unless out_stall_i holds them
// back, produced by a single 16-bit offset adder stepped by a page counter; the input side
// stalls for the whole burst. the output has its own register, so the next input word is
// taken in the same cycle as a waiting result leaves. page buffer entries never written
// since reset read as zero through per-entry valid flags; no clearing pass runs after
// reset. configuration writes are taken every cycle (cfg_ready_o is always high) and
// should only be made while idle.
`default_nettype none

module serial_page_memory_programmer_core import spmp_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // input words
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              req_type_i,
  input  wire logic [BYTE_W-1:0] rx_byte_i,
  input  wire logic [BYTE_W-1:0] mem_data_i,
  // result words
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic      [1:0]        mem_op_o,
  output logic      [ADDR_W-1:0] mem_address_o,
  output logic      [BYTE_W-1:0] mem_wdata_o,
  output logic                   tx_valid_o,
  output logic      [BYTE_W-1:0] tx_byte_o,
  output logic                   release_bus_o,
  output logic                   last_o,
  // register writes
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [1:0]        cfg_index_i,
  input  wire logic [BYTE_W-1:0] cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LEN_LO,
    ST_LEN_HI,
    ST_OFF_LO,
    ST_OFF_HI,
    ST_DATA,
    ST_READ_WAIT,
    ST_RD_BURST,
    ST_WR_BURST
  } state_e;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_READ,
    CMD_WRITE,
    CMD_STORE
  } cmd_e;

  state_e               state_q, state_d;
  cmd_e                 cmd_q, cmd_d;
  logic [ADDR_W-1:0]    len_q, len_d;
  logic [ADDR_W-1:0]    off_q, off_d;
  logic [STORE_IW-1:0]  store_idx_q, store_idx_d;
  logic [PAGE_CW-1:0]   read_idx_q, read_idx_d;
  logic [PAGE_CW-1:0]   idx_q, idx_d;
  logic [BYTE_W-1:0]    read_code_q, write_code_q, store_code_q, ack_code_q;

  logic                 in_acc;
  logic                 out_ready;
  logic                 emit;
  res_t                 res;
  res_t                 res_out;
  logic [ADDR_W-1:0]    addr_sum;
  logic                 page_end;
  logic [PAGE_CW-1:0]   read_idx_nxt;
  logic                 buf_we;
  logic [BYTE_W-1:0]    buf_rdata;

  // no input word during a page burst or while the result slot is full
  assign in_stall_o  = (state_q == ST_RD_BURST) || (state_q == ST_WR_BURST) || !out_ready;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // the shared unit: page offset plus burst index, wrapping at 16 bits
  assign addr_sum     = off_q + ADDR_W'(idx_q);
  assign page_end     = (idx_q == PAGE_CW'(PAGE_SIZE - 1));
  assign read_idx_nxt = read_idx_q + PAGE_CW'(1);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    len_d       = len_q;
    off_d       = off_q;
    store_idx_d = store_idx_q;
    read_idx_d  = read_idx_q;
    idx_d       = idx_q;
    buf_we      = 1'b0;
    emit        = 1'b0;
    res         = '0;

    unique case (state_q)
      ST_IDLE: begin
        // commands are only recognised here; read wins, then write, then store
        if (in_acc && !req_type_i) begin
          if (rx_byte_i == read_code_q) begin
            cmd_d   = CMD_READ;
            state_d = ST_LEN_LO;
          end else if (rx_byte_i == write_code_q) begin
            cmd_d   = CMD_WRITE;
            state_d = ST_LEN_LO;
          end else if (rx_byte_i == store_code_q) begin
            cmd_d   = CMD_STORE;
            state_d = ST_LEN_LO;
          end
        end
      end
      ST_LEN_LO: begin
        if (in_acc && !req_type_i) begin
          len_d   = {{(ADDR_W-BYTE_W){1'b0}}, rx_byte_i};
          state_d = ST_LEN_HI;
        end
      end
      ST_LEN_HI: begin
        if (in_acc && !req_type_i) begin
          len_d   = {rx_byte_i, len_q[BYTE_W-1:0]};
          state_d = ST_OFF_LO;
        end
      end
      ST_OFF_LO: begin
        if (in_acc && !req_type_i) begin
          off_d   = {{(ADDR_W-BYTE_W){1'b0}}, rx_byte_i};
          state_d = ST_OFF_HI;
        end
      end
      ST_OFF_HI: begin
        if (in_acc && !req_type_i) begin
          off_d       = {rx_byte_i, off_q[BYTE_W-1:0]};
          store_idx_d = '0;
          if (cmd_q == CMD_READ) begin
            read_idx_d = '0;
            idx_d      = '0;
            state_d    = ST_RD_BURST;
          end else begin
            state_d = ST_DATA;
          end
        end
      end
      ST_DATA: begin
        if (in_acc && !req_type_i) begin
          case (cmd_q)
            CMD_WRITE: begin
              // any byte triggers the page write
              idx_d   = '0;
              state_d = ST_WR_BURST;
            end
            CMD_STORE: begin
              if (store_idx_q < STORE_IW'(BUF_DEPTH)) begin
                buf_we      = 1'b1;
                store_idx_d = store_idx_q + STORE_IW'(1);
              end
              if (len_q == '0) begin
                store_idx_d     = '0;
                cmd_d           = CMD_NONE;
                state_d         = ST_IDLE;
                emit            = 1'b1;
                res.mem_op      = MEM_NONE;
                res.tx_valid    = 1'b1;
                res.tx_byte     = ack_code_q;
                res.last        = 1'b1;
              end else begin
                len_d = len_q - ADDR_W'(1);
              end
            end
            default: begin
              cmd_d   = CMD_NONE;
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_READ_WAIT: begin
        // serial bytes are dropped here, returned memory bytes go to the host
        if (in_acc && req_type_i) begin
          emit         = 1'b1;
          res.mem_op   = MEM_NONE;
          res.tx_valid = 1'b1;
          res.tx_byte  = mem_data_i;
          res.last     = 1'b1;
          if (read_idx_nxt >= PAGE_CW'(PAGE_SIZE)) begin
            read_idx_d      = '0;
            cmd_d           = CMD_NONE;
            state_d         = ST_IDLE;
            res.release_bus = 1'b1;
          end else begin
            read_idx_d = read_idx_nxt;
          end
        end
      end
      ST_RD_BURST: begin
        if (out_ready) begin
          emit            = 1'b1;
          res.mem_op      = MEM_READ;
          res.mem_address = addr_sum;
          res.last        = page_end;
          idx_d           = idx_q + PAGE_CW'(1);
          if (page_end) begin
            state_d = ST_READ_WAIT;
          end
        end
      end
      ST_WR_BURST: begin
        // buffer data for idx_q is already registered at the buffer output
        if (out_ready) begin
          emit            = 1'b1;
          res.mem_op      = MEM_WRITE;
          res.mem_address = addr_sum;
          res.mem_wdata   = buf_rdata;
          idx_d           = idx_q + PAGE_CW'(1);
          if (page_end) begin
            res.tx_valid    = 1'b1;
            res.tx_byte     = ack_code_q;
            res.release_bus = 1'b1;
            res.last        = 1'b1;
            cmd_d           = CMD_NONE;
            state_d         = ST_IDLE;
          end
        end
      end
      default: begin
        cmd_d   = CMD_NONE;
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cmd_q        <= CMD_NONE;
      len_q        <= '0;
      off_q        <= '0;
      store_idx_q  <= '0;
      read_idx_q   <= '0;
      idx_q        <= '0;
      read_code_q  <= BYTE_W'(1);
      write_code_q <= BYTE_W'(2);
      store_code_q <= BYTE_W'(3);
      ack_code_q   <= BYTE_W'(6);
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      len_q       <= len_d;
      off_q       <= off_d;
      store_idx_q <= store_idx_d;
      read_idx_q  <= read_idx_d;
      idx_q       <= idx_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_READ:  read_code_q  <= cfg_data_i;
          CFG_WRITE: write_code_q <= cfg_data_i;
          CFG_STORE: store_code_q <= cfg_data_i;
          CFG_ACK:   ack_code_q   <= cfg_data_i;
          default:   ;
        endcase
      end
    end
  end

  // buffer is read ahead at the next burst index
  spmp_page_buf u_page_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (buf_we),
    .wr_addr_i (BUF_AW'(store_idx_q)),
    .wr_data_i (rx_byte_i),
    .rd_addr_i (BUF_AW'(idx_d)),
    .rd_data_o (buf_rdata)
  );

  spmp_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (emit),
    .res_i   (res),
    .stall_i (out_stall_i),
    .ready_o (out_ready),
    .valid_o (out_valid_o),
    .res_o   (res_out)
  );

  assign mem_op_o      = res_out.mem_op;
  assign mem_address_o = res_out.mem_address;
  assign mem_wdata_o   = res_out.mem_wdata;
  assign tx_valid_o    = res_out.tx_valid;
  assign tx_byte_o     = res_out.tx_byte;
  assign release_bus_o = res_out.release_bus;
  assign last_o        = res_out.last;

endmodule

`default_nettype wire

>>> sv/spmp_checker.sv
`default_nettype none
`include "assert_macros.svh"

module spmp_checker import spmp_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_stall_i,
  input wire logic              out_valid_i,
  input wire logic              out_stall_i,
  input wire logic [1:0]        mem_op_i,
  input wire logic [ADDR_W-1:0] mem_address_i,
  input wire logic              tx_valid_i,
  input wire logic [BYTE_W-1:0] tx_byte_i,
  input wire logic              release_bus_i,
  input wire logic              last_i
);

  logic                     out_held;
  logic [ADDR_W+BYTE_W-1:0] out_word;

  assign out_held = out_valid_i && out_stall_i;
  assign out_word = {mem_address_i, tx_byte_i};

  // held result keeps its payload
  `SPMP_ASSERT(a_out_hold, clk_i, rst_ni, out_held |=> out_valid_i && $stable(out_word))
  // no input word taken while the result slot is blocked
  `SPMP_ASSERT(a_in_blocked, clk_i, rst_ni, out_held |-> in_stall_i)
  // a result without a memory access always carries a host byte
  `SPMP_NEVER(a_none_tx, clk_i, rst_ni, out_valid_i && (mem_op_i == MEM_NONE) && !tx_valid_i)
  // bus release only on the closing word of a step
  `SPMP_NEVER(a_rel_last, clk_i, rst_ni, out_valid_i && release_bus_i && !last_i)

endmodule

bind serial_page_memory_programmer_core spmp_checker u_spmp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_i    (in_stall_o),
  .out_valid_i   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .mem_op_i      (mem_op_o),
  .mem_address_i (mem_address_o),
  .tx_valid_i    (tx_valid_o),
  .tx_byte_i     (tx_byte_o),
  .release_bus_i (release_bus_o),
  .last_i        (last_o)
);

`default_nettype wire

>>> tb/sv/spmp_page_checker.sv
module spmp_page_checker import spmp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic              req_type_i,
  input  logic [BYTE_W-1:0] rx_byte_i,
  input  logic [BYTE_W-1:0] mem_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [1:0]        mem_op_i,
  input  logic [ADDR_W-1:0] mem_address_i,
  input  logic [BYTE_W-1:0] mem_wdata_i,
  input  logic              tx_valid_i,
  input  logic [BYTE_W-1:0] tx_byte_i,
  input  logic              release_bus_i,
  input  logic              last_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [BYTE_W-1:0] cfg_data_i,
  output int                fail_count_o,
  output int                pending_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_LEN_LO, ST_LEN_HI, ST_OFS_LO, ST_OFS_HI, ST_BODY, ST_AWAIT_DATA
  } seq_state_e;

  typedef enum logic [1:0] {OP_NONE, OP_READ, OP_WRITE, OP_STORE} seq_op_e;

  seq_state_e        seq_state;
  seq_op_e           seq_op;
  logic [15:0]       count_left;
  logic [15:0]       page_base;
  int                fill_ptr;
  logic [6:0]        return_ptr;
  logic [7:0]        page_buf [BUF_DEPTH];
  logic [7:0]        read_code, write_code, store_code, ack_code;
  res_t              bus_words_due [$];
  res_t              want;
  int                fails;

  function automatic void expect_word(mem_op_e op, logic [15:0] addr, logic [7:0] wdata,
                                      logic txv, logic [7:0] txb, logic rel, logic lst);
    res_t w;
    w.mem_op      = op;
    w.mem_address = addr;
    w.mem_wdata   = wdata;
    w.tx_valid    = txv;
    w.tx_byte     = txb;
    w.release_bus = rel;
    w.last        = lst;
    bus_words_due.push_back(w);
  endfunction

  task automatic go_idle();
    seq_state = ST_IDLE;
    seq_op    = OP_NONE;
  endtask

  // frame parser, one accepted input word at a time
  task automatic follow_word(input logic req, input logic [7:0] rx, input logic [7:0] md);
    logic fin;
    if (req) begin
      if (seq_state != ST_AWAIT_DATA) return;
      return_ptr = return_ptr + 7'd1;
      fin = (return_ptr >= PAGE_SIZE);
      if (fin) begin
        return_ptr = '0;
        go_idle();
      end
      expect_word(MEM_NONE, '0, '0, 1'b1, md, fin, 1'b1);
      return;
    end
    case (seq_state)
      ST_LEN_LO: begin
        count_left = {8'h00, rx};
        seq_state  = ST_LEN_HI;
      end
      ST_LEN_HI: begin
        count_left[15:8] = rx;
        seq_state        = ST_OFS_LO;
      end
      ST_OFS_LO: begin
        page_base = {8'h00, rx};
        seq_state = ST_OFS_HI;
      end
      ST_OFS_HI: begin
        page_base[15:8] = rx;
        fill_ptr        = 0;
        if (seq_op == OP_READ) begin
          return_ptr = '0;
          seq_state  = ST_AWAIT_DATA;
          for (int i = 0; i < PAGE_SIZE; i++)
            expect_word(MEM_READ, page_base + 16'(i), '0, 1'b0, '0, 1'b0,
                        i == PAGE_SIZE - 1);
        end else begin
          seq_state = ST_BODY;
        end
      end
      ST_BODY: begin
        if (seq_op == OP_WRITE) begin
          for (int i = 0; i < PAGE_SIZE; i++) begin
            fin = (i == PAGE_SIZE - 1);
            expect_word(MEM_WRITE, page_base + 16'(i), (i < BUF_DEPTH) ? page_buf[i] : 8'h00,
                        fin, fin ? ack_code : 8'h00, fin, fin);
          end
          go_idle();
        end else if (seq_op == OP_STORE) begin
          // bytes past the buffer end are counted but dropped
          if (fill_ptr < BUF_DEPTH) begin
            page_buf[fill_ptr] = rx;
            fill_ptr++;
          end
          if (count_left == 16'd0) begin
            fill_ptr = 0;
            go_idle();
            expect_word(MEM_NONE, '0, '0, 1'b1, ack_code, 1'b0, 1'b1);
          end else begin
            count_left--;
          end
        end else begin
          go_idle();
        end
      end
      ST_AWAIT_DATA: begin
      end
      default: begin
        // commands only count here; read beats write beats store
        go_idle();
        if (rx == read_code) seq_op = OP_READ;
        else if (rx == write_code) seq_op = OP_WRITE;
        else if (rx == store_code) seq_op = OP_STORE;
        if (seq_op != OP_NONE) seq_state = ST_LEN_LO;
      end
    endcase
  endtask

  task automatic check_field(input string what, input logic [15:0] want_v,
                             input logic [15:0] got_v);
    if (want_v !== got_v) begin
      fails++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want_v, got_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      go_idle();
      count_left   = '0;
      page_base    = '0;
      fill_ptr     = 0;
      return_ptr   = '0;
      foreach (page_buf[i]) page_buf[i] = 8'h00;
      read_code    = 8'd1;
      write_code   = 8'd2;
      store_code   = 8'd3;
      ack_code     = 8'd6;
      bus_words_due.delete();
      fails        = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_READ:  read_code  = cfg_data_i;
          CFG_WRITE: write_code = cfg_data_i;
          CFG_STORE: store_code = cfg_data_i;
          CFG_ACK:   ack_code   = cfg_data_i;
          default: begin
          end
        endcase
      end
      if (in_valid_i && !in_stall_i)
        follow_word(req_type_i, rx_byte_i, mem_data_i);
      if (out_valid_i && !out_stall_i) begin
        if (bus_words_due.size() == 0) begin
          fails++;
          $display("%0t: unexpected result word, expected none, got op %0h addr %0h tx %0h",
                   $time, mem_op_i, mem_address_i, tx_byte_i);
        end else begin
          want = bus_words_due.pop_front();
          check_field("mem_op", 16'(want.mem_op), 16'(mem_op_i));
          check_field("mem_address", want.mem_address, mem_address_i);
          check_field("mem_wdata", 16'(want.mem_wdata), 16'(mem_wdata_i));
          check_field("tx_valid", 16'(want.tx_valid), 16'(tx_valid_i));
          check_field("tx_byte", 16'(want.tx_byte), 16'(tx_byte_i));
          check_field("release_bus", 16'(want.release_bus), 16'(release_bus_i));
          check_field("last", 16'(want.last), 16'(last_i));
        end
      end
      fail_count_o <= fails;
      pending_o    <= bus_words_due.size();
    end
  end

endmodule

>>> tb/sv/testbench.sv
module testbench;
  import spmp_pkg::*;

  // slowest correct run: ~430 words, each at worst a 64-word page burst with every
  // result held up by output stalls, plus sender gaps; well under this bound
  localparam int LIMIT = 1_000_000;

  typedef enum logic [1:0] {F_STORE, F_WRITE, F_READ} frame_kind_e;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              req_type;
  logic [BYTE_W-1:0] rx_byte;
  logic [BYTE_W-1:0] mem_data;
  logic              out_valid;
  logic              out_stall;
  logic [1:0]        mem_op;
  logic [ADDR_W-1:0] mem_address;
  logic [BYTE_W-1:0] mem_wdata;
  logic              tx_valid;
  logic [BYTE_W-1:0] tx_byte;
  logic              release_bus;
  logic              last;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [1:0]        cfg_index;
  logic [BYTE_W-1:0] cfg_data;

  int                fail_count;
  int                pending;
  int                cycles = 0;
  int                stall_left = 0;
  int                words_sent = 0;
  bit                gaps_on = 1'b0;
  bit                rand_phase = 1'b0;
  // testbench copy of the command and ack codes, indexed by register
  logic [7:0]        codes [4];

  serial_page_memory_programmer_core DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .req_type_i   (req_type),
    .rx_byte_i    (rx_byte),
    .mem_data_i   (mem_data),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .mem_op_o     (mem_op),
    .mem_address_o(mem_address),
    .mem_wdata_o  (mem_wdata),
    .tx_valid_o   (tx_valid),
    .tx_byte_o    (tx_byte),
    .release_bus_o(release_bus),
    .last_o       (last),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  spmp_page_checker page_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .req_type_i   (req_type),
    .rx_byte_i    (rx_byte),
    .mem_data_i   (mem_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .mem_op_i     (mem_op),
    .mem_address_i(mem_address),
    .mem_wdata_i  (mem_wdata),
    .tx_valid_i   (tx_valid),
    .tx_byte_i    (tx_byte),
    .release_bus_i(release_bus),
    .last_i       (last),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: random stall bursts while idling is allowed
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 6);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // one input word, with an optional idle gap in front;
  // returns on the edge where the word is taken
  task automatic send_word(input logic r, input logic [7:0] b, input logic [7:0] d);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= r;
    rx_byte  <= b;
    mem_data <= d;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // complete frame: command, length lo/hi, offset lo/hi, then the body that the
  // command really selects (coinciding codes resolve read, then write, then store)
  task automatic send_frame(input logic [7:0] cmd, input logic [15:0] len,
                            input logic [15:0] ofs);
    frame_kind_e kind;
    kind = (cmd == codes[CFG_READ])  ? F_READ :
           (cmd == codes[CFG_WRITE]) ? F_WRITE : F_STORE;
    gaps_on = rand_phase && ($urandom_range(0, 3) != 0);
    send_word(1'b0, cmd, rand_byte());
    send_word(1'b0, len[7:0], rand_byte());
    send_word(1'b0, len[15:8], rand_byte());
    send_word(1'b0, ofs[7:0], rand_byte());
    send_word(1'b0, ofs[15:8], rand_byte());
    words_sent += 5;
    case (kind)
      F_STORE: begin
        repeat (int'(len) + 1) send_word(1'b0, rand_byte(), rand_byte());
        words_sent += int'(len) + 1;
      end
      F_WRITE: begin
        // any byte triggers the page write, a command code too
        send_word(1'b0, rand_byte(), rand_byte());
        words_sent += 1;
      end
      default: begin
        // memory returns, with the odd serial byte thrown in (ignored while reading)
        repeat (PAGE_SIZE) begin
          if ($urandom_range(0, 15) == 0) send_word(1'b0, rand_byte(), rand_byte());
          send_word(1'b1, rand_byte(), rand_byte());
        end
        words_sent += PAGE_SIZE;
      end
    endcase
  endtask

  // stray word between frames: a non-command byte or memory data with no read open
  task automatic send_stray();
    logic [7:0] b;
    if ($urandom_range(0, 1) == 0) begin
      send_word(1'b1, rand_byte(), rand_byte());
    end else begin
      do b = rand_byte();
      while (b == codes[CFG_READ] || b == codes[CFG_WRITE] ||
             b == codes[CFG_STORE] || b == codes[CFG_ACK]);
      send_word(1'b0, b, rand_byte());
    end
  endtask

  task automatic random_frame();
    int          pick;
    logic [15:0] len;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      send_stray();
    end else if (pick < 55) begin
      // mostly short stores, now and then a long one near or past the buffer end
      len = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(120, 140))
                                         : 16'($urandom_range(0, 15));
      send_frame(codes[CFG_STORE], len, 16'($urandom_range(0, 65535)));
    end else if (pick < 80) begin
      send_frame(codes[CFG_WRITE], 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 65535)));
    end else begin
      send_frame(codes[CFG_READ], 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 65535)));
    end
  endtask

  // sender holds off until every result is back, lets the block settle, then
  // rewrites all four registers
  task automatic set_codes(input logic [7:0] rc, input logic [7:0] wc,
                           input logic [7:0] sc, input logic [7:0] ac);
    logic [7:0] vals [4];
    vals = '{rc, wc, sc, ac};
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
    for (int k = 0; k < 4; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 2'(k);
      cfg_data  <= vals[k];
      do @(posedge clk); while (!cfg_ready);
      codes[k] = vals[k];
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_until(input int target);
    while (words_sent < target) random_frame();
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    req_type  = 1'b0;
    rx_byte   = '0;
    mem_data  = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_READ;
    cfg_data  = '0;
    codes     = '{8'd1, 8'd2, 8'd3, 8'd6};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words, no idling
    send_word(1'b0, 8'h00, 8'h00);          // idle byte that is no command
    send_word(1'b0, 8'hFF, 8'hFF);
    send_word(1'b1, 8'h00, 8'hFF);          // memory data with no read open
    // length low equals the read code: taken as header, not a command
    send_frame(codes[CFG_STORE], 16'h0001, 16'hFFFF);
    // length ignored, addresses wrap past 0xffff
    send_frame(codes[CFG_WRITE], 16'hFFFF, 16'hFFF8);
    send_frame(codes[CFG_STORE], 16'h0000, 16'h0000);

    // random frames with idling on both sides in random stretches
    rand_phase = 1'b1;
    send_frame(codes[CFG_READ], 16'h0000, 16'hFFE0);
    send_frame(codes[CFG_STORE], 16'd129, 16'($urandom_range(0, 65535)));
    send_frame(codes[CFG_WRITE], 16'h0000, 16'h0100);
    run_until(110);

    // extreme codes, zero ack
    set_codes(8'h00, 8'hFF, 8'h80, 8'h00);
    run_until(190);

    // all codes the same: every command is a read
    set_codes(8'h55, 8'h55, 8'h55, 8'hFF);
    run_until(250);

    // write and store share a code: write wins
    set_codes(8'h10, 8'hAA, 8'hAA, 8'h7E);
    run_until(310);

    // random codes, and a tail with no idling at all
    set_codes(rand_byte(), rand_byte(), rand_byte(), rand_byte());
    run_until(350);
    rand_phase = 1'b0;
    gaps_on    = 1'b0;
    run_until(430);

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
